FILE: design/egls_pkg.sv
// Shared types, widths and helpers for the edge gradient local system.
// Used by the top level and the testbench; the divider and square-root pipelines do not use it.
package egls_pkg;

    localparam int NODES_PER_EDGE = 2;
    localparam int ROWS_MAX       = 6;
    localparam int DIFF_W         = 33;
    localparam int MAG_W          = 32;
    localparam int PROD_W         = 64;
    localparam int Q_W            = 66;
    localparam int DEN_W          = 67;
    localparam int MAT_SHIFT      = 31;
    localparam int RHS_SHIFT      = 18;
    localparam int MAT_NUM_W      = 96;
    localparam int RHS_NUM_W      = 83;
    localparam int QUOT_W         = 33;
    localparam int ROOT_W         = 33;
    localparam int EPS_K_W        = 25;
    localparam int EPS_PROD_W     = ROOT_W + EPS_K_W;
    localparam int EPS_W          = 28;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 2;

    localparam logic [EPS_K_W-1:0] EPS_K = 25'd17592186;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_COMPONENT = 1'b1;

    localparam logic [1:0] DIM_TWO   = 2'd2;
    localparam logic [1:0] DIM_THREE = 2'd3;
    localparam logic [1:0] VC_X      = 2'd0;
    localparam logic [1:0] VC_Y      = 2'd1;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic signed [31:0] first_vel_z;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic signed [31:0] second_vel_z;
    } egls_in_t;

    typedef struct packed {
        logic        [2:0]  row_index;
        logic signed [31:0] entry_0;
        logic signed [31:0] entry_1;
        logic signed [31:0] entry_2;
        logic signed [31:0] entry_3;
        logic signed [31:0] entry_4;
        logic signed [31:0] entry_5;
        logic signed [31:0] rhs_entry;
        logic               degenerate;
        logic               last_row;
    } egls_out_t;

    // Sign and clamp an unsigned quotient into the signed 32-bit range.
    function automatic logic [31:0] sat_mag(input logic [QUOT_W-1:0] mag,
                                            input logic ovf, input logic neg);
        logic big;
        big = ovf | mag[QUOT_W-1] | mag[QUOT_W-2];
        if (big)
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            return neg ? (~{1'b0, mag[30:0]} + 32'd1) : {1'b0, mag[30:0]};
    endfunction

endpackage

FILE: design/egls_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No package dependency.
module egls_div #(
    parameter int NW = 96,
    parameter int DW = 67,
    parameter int QW = 33
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quot,
    output logic          ovf
);

    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [QW-1:0] quot_reg [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic          ovf_reg  [QW+1];

    // The upper part of the numerator must already be below the divisor,
    // otherwise the quotient does not fit and only the flag matters.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(num[NW-1:QW]);
        ovf_reg[0]  <= DW'(num[NW-1:QW]) >= den;
        low_reg[0]  <= num[QW-1:0];
        quot_reg[0] <= '0;
        den_reg[0]  <= den;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        assign trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign take  = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? diff[DW-1:0] : trial[DW-1:0];
            low_reg[k]  <= {low_reg[k-1][QW-2:0], 1'b0};
            quot_reg[k] <= {quot_reg[k-1][QW-2:0], take};
            den_reg[k]  <= den_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
        end
    end

    assign quot = quot_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

FILE: design/egls_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor of the root).
// No package dependency.
module egls_sqrt #(
    parameter int IW = 66,
    parameter int RW = 33
) (
    input  logic          clk,
    input  logic [IW-1:0] val,
    output logic [RW-1:0] root
);

    logic [IW-1:0] v_reg   [RW];
    logic [IW:0]   res_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam logic [IW:0] BIT_K = (IW+1)'(1) << (2 * (RW - 1 - k));
        logic [IW-1:0] v_in;
        logic [IW:0]   res_in;
        logic [IW:0]   t;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_in   = val;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign t  = res_in + BIT_K;
        assign ge = {1'b0, v_in} >= t;

        always_ff @(posedge clk)
        begin
            v_reg[k]   <= ge ? (v_in - t[IW-1:0]) : v_in;
            res_reg[k] <= ge ? ((res_in >> 1) + BIT_K) : (res_in >> 1);
        end
    end

    assign root = res_reg[RW-1][RW-1:0];

endmodule

FILE: design/edge_gradient_local_system_top.sv
// Edge gradient local system: top level with front pipeline and row emitter.
// Depends on egls_pkg, egls_div and egls_sqrt.
//
// Usage: an edge item (two node positions and velocities, Q16.16) is taken
// at a clock edge with start high and busy low. For each edge the block
// emits 2*dimension rows on row_data, one per cycle, each marked by a
// one-cycle row_valid; last_row flags the final row. Rows cannot be held
// off by the receiver, so none are ever stalled or dropped.
// The first row of an edge appears once the edge has passed the front
// stages, the dividers and square root, and the final hold registers;
// the remaining rows follow in consecutive cycles. No new edge is taken
// while busy is high; busy is set when an edge is taken and counts down so
// that the rows of successive edges do not overlap. The arithmetic is a
// 39-stage pipeline of products, 33-bit restoring dividers and a pipelined square root.
// Configuration: cfg_we with cfg_index 0 writes dimension, index 1 writes
// velocity_component; write only while no edge is in flight.
// Reset clears the pipeline valids and the emitter, sets dimension to 3
// and velocity_component to 0.
module edge_gradient_local_system_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  egls_pkg::egls_in_t                  edge_data,
    input  logic                                cfg_we,
    input  logic [egls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egls_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                row_valid,
    output egls_pkg::egls_out_t                 row_data
);

    import egls_pkg::*;

    localparam int UNIT_LAT = QUOT_W + 1;

    typedef struct packed {
        logic       dim3;
        logic [2:0] sgn;
        logic       dv_sgn;
        logic       degen;
    } side_t;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] x);
        logic [DIFF_W-1:0] n;
        n = x[DIFF_W-1] ? -x : x;
        return n[MAG_W-1:0];
    endfunction

    function automatic logic [PROD_W-1:0] mul32(input logic [MAG_W-1:0] a,
                                                input logic [MAG_W-1:0] b);
        logic [PROD_W-1:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p;
    endfunction

    // Configuration and input throttle
    logic [1:0] dim_reg;
    logic [1:0] vc_reg;
    logic [2:0] cool_reg;
    logic       accept;

    assign busy   = cool_reg != 3'd0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= DIM_THREE;
            vc_reg   <= VC_X;
            cool_reg <= 3'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DIMENSION)
                dim_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == CFG_VEL_COMPONENT)
                vc_reg <= cfg_data[1:0];
            if (accept)
                cool_reg <= (dim_reg == DIM_TWO) ? 3'd3 : 3'd5;
            else if (busy)
                cool_reg <= cool_reg - 3'd1;
        end
    end

    // Stage 1: differences
    logic signed [DIFF_W-1:0] le_next [3];
    logic signed [DIFF_W-1:0] dv_next;
    logic signed [31:0]       vel_a;
    logic signed [31:0]       vel_b;

    always_comb
    begin
        le_next[0] = DIFF_W'(edge_data.second_x) - DIFF_W'(edge_data.first_x);
        le_next[1] = DIFF_W'(edge_data.second_y) - DIFF_W'(edge_data.first_y);
        le_next[2] = DIFF_W'(edge_data.second_z) - DIFF_W'(edge_data.first_z);
        case (vc_reg)
            VC_X:
            begin
                vel_a = edge_data.first_vel_x;
                vel_b = edge_data.second_vel_x;
            end
            VC_Y:
            begin
                vel_a = edge_data.first_vel_y;
                vel_b = edge_data.second_vel_y;
            end
            default:
            begin
                vel_a = edge_data.first_vel_z;
                vel_b = edge_data.second_vel_z;
            end
        endcase
        dv_next = DIFF_W'(vel_b) - DIFF_W'(vel_a);
    end

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [DIFF_W-1:0] le1_reg [3];
    logic signed [DIFF_W-1:0] dv1_reg;
    logic                     dim3_1_reg;
    logic [MAG_W-1:0]         mag2_reg [3];
    logic [MAG_W-1:0]         dvmag2_reg;
    side_t                    side2_reg, side3_reg, side4_reg, side5_reg;
    logic [PROD_W-1:0]        sq3_reg [3];
    logic [PROD_W-1:0]        cr3_reg [3];
    logic [PROD_W-1:0]        rp3_reg [3];
    logic [PROD_W-1:0]        sq4_reg [3];
    logic [PROD_W-1:0]        cr4_reg [3];
    logic [PROD_W-1:0]        rp4_reg [3];
    logic [Q_W-1:0]           q4_reg;
    logic [MAT_NUM_W-1:0]     mat_num5_reg [6];
    logic [RHS_NUM_W-1:0]     rhs_num5_reg [3];
    logic [DEN_W-1:0]         den5_reg;
    logic [Q_W-1:0]           q5_reg;

    logic                     vline_reg [UNIT_LAT];
    side_t                    sline_reg [UNIT_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int k = 0; k < UNIT_LAT; k++)
                vline_reg[k] <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vline_reg[0] <= v5_reg;
            for (int k = 1; k < UNIT_LAT; k++)
                vline_reg[k] <= vline_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1
        for (int k = 0; k < 3; k++)
            le1_reg[k] <= le_next[k];
        dv1_reg    <= dv_next;
        dim3_1_reg <= dim_reg != DIM_TWO;

        // Stage 2: magnitudes and signs
        for (int k = 0; k < 3; k++)
        begin
            mag2_reg[k]      <= abs_diff(le1_reg[k]);
            side2_reg.sgn[k] <= le1_reg[k][DIFF_W-1];
        end
        dvmag2_reg       <= abs_diff(dv1_reg);
        side2_reg.dv_sgn <= dv1_reg[DIFF_W-1];
        side2_reg.dim3   <= dim3_1_reg;
        side2_reg.degen  <= 1'b0;

        // Stage 3: squares, cross products (xy, xz, yz) and velocity products
        for (int k = 0; k < 3; k++)
        begin
            sq3_reg[k] <= mul32(mag2_reg[k], mag2_reg[k]);
            rp3_reg[k] <= mul32(mag2_reg[k], dvmag2_reg);
        end
        cr3_reg[0] <= mul32(mag2_reg[0], mag2_reg[1]);
        cr3_reg[1] <= mul32(mag2_reg[0], mag2_reg[2]);
        cr3_reg[2] <= mul32(mag2_reg[1], mag2_reg[2]);
        side3_reg  <= side2_reg;

        // Stage 4: squared length
        q4_reg <= Q_W'(sq3_reg[0]) + Q_W'(sq3_reg[1]) + Q_W'(sq3_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            sq4_reg[k] <= sq3_reg[k];
            cr4_reg[k] <= cr3_reg[k];
            rp4_reg[k] <= rp3_reg[k];
        end
        side4_reg <= side3_reg;

        // Stage 5: rounded-division operands, numerator 2n+q over 2q
        for (int k = 0; k < 3; k++)
        begin
            mat_num5_reg[k]   <= {1'b0, sq4_reg[k], {MAT_SHIFT{1'b0}}} + MAT_NUM_W'(q4_reg);
            mat_num5_reg[3+k] <= {1'b0, cr4_reg[k], {MAT_SHIFT{1'b0}}} + MAT_NUM_W'(q4_reg);
            rhs_num5_reg[k]   <= {1'b0, rp4_reg[k], {RHS_SHIFT{1'b0}}} + RHS_NUM_W'(q4_reg);
        end
        den5_reg  <= {q4_reg, 1'b0};
        q5_reg    <= q4_reg;
        side5_reg <= {side4_reg.dim3, side4_reg.sgn, side4_reg.dv_sgn, q4_reg == '0};

        sline_reg[0] <= side5_reg;
        for (int k = 1; k < UNIT_LAT; k++)
            sline_reg[k] <= sline_reg[k-1];
    end

    // Division and square-root units
    logic [QUOT_W-1:0] mat_quot [6];
    logic              mat_ovf  [6];
    logic [QUOT_W-1:0] rhs_quot [3];
    logic              rhs_ovf  [3];
    logic [ROOT_W-1:0] root;

    for (genvar g = 0; g < 6; g++)
    begin : g_mat_div
        egls_div #(
            .NW (MAT_NUM_W),
            .DW (DEN_W),
            .QW (QUOT_W)
        ) u_div (
            .clk  (clk),
            .num  (mat_num5_reg[g]),
            .den  (den5_reg),
            .quot (mat_quot[g]),
            .ovf  (mat_ovf[g])
        );
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_rhs_div
        egls_div #(
            .NW (RHS_NUM_W),
            .DW (DEN_W),
            .QW (QUOT_W)
        ) u_div (
            .clk  (clk),
            .num  (rhs_num5_reg[g]),
            .den  (den5_reg),
            .quot (rhs_quot[g]),
            .ovf  (rhs_ovf[g])
        );
    end

    egls_sqrt #(
        .IW (Q_W),
        .RW (ROOT_W)
    ) u_sqrt (
        .clk  (clk),
        .val  (q5_reg),
        .root (root)
    );

    // The epsilon term is 1e-6 times the root, rounded, in Q2.30.
    logic [EPS_PROD_W-1:0] eps_prod;
    logic [EPS_W-1:0]      eps_reg;

    assign eps_prod = {{EPS_K_W{1'b0}}, root} * {{ROOT_W{1'b0}}, EPS_K}
                    + (EPS_PROD_W'(1) << 29);

    always_ff @(posedge clk)
    begin
        eps_reg <= eps_prod[EPS_W+29:30];
    end

    // Stage 40: final values for the whole edge, held while rows go out
    logic [31:0] plus_reg  [3];
    logic [31:0] minus_reg [3];
    logic [31:0] off_reg   [3];
    logic [31:0] rhs_reg   [3];
    logic        hold_degen_reg;
    logic        hold_dim3_reg;
    side_t       s39;
    logic        load;
    logic [31:0] base32 [3];
    logic [31:0] eps32;

    assign s39   = sline_reg[UNIT_LAT-1];
    assign load  = vline_reg[UNIT_LAT-1];
    assign eps32 = {{(32-EPS_W){1'b0}}, eps_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            base32[k] = {1'b0, mat_quot[k][30:0]};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                plus_reg[k]  <= base32[k] + eps32;
                minus_reg[k] <= base32[k] - eps32;
                rhs_reg[k]   <= sat_mag(rhs_quot[k], rhs_ovf[k], s39.sgn[k] ^ s39.dv_sgn);
            end
            off_reg[0]     <= sat_mag(mat_quot[3], mat_ovf[3], s39.sgn[0] ^ s39.sgn[1]);
            off_reg[1]     <= sat_mag(mat_quot[4], mat_ovf[4], s39.sgn[0] ^ s39.sgn[2]);
            off_reg[2]     <= sat_mag(mat_quot[5], mat_ovf[5], s39.sgn[1] ^ s39.sgn[2]);
            hold_degen_reg <= s39.degen;
            hold_dim3_reg  <= s39.dim3;
        end
    end

    // Row emitter
    logic        active_reg;
    logic [2:0]  row_reg;
    logic        e_reg;
    logic [1:0]  i_reg;
    logic        row_valid_reg;
    egls_out_t   out_reg;
    egls_out_t   out_next;
    logic [2:0]  size_m1;
    logic [1:0]  dim_m1;
    logic [31:0] ent [ROWS_MAX];

    assign size_m1 = hold_dim3_reg ? 3'd5 : 3'd3;
    assign dim_m1  = hold_dim3_reg ? 2'd2 : 2'd1;

    always_comb
    begin
        logic       col_f;
        logic [1:0] col_j;
        logic       col_ok;
        logic [1:0] off_idx;
        for (int k = 0; k < ROWS_MAX; k++)
        begin
            col_f   = hold_dim3_reg ? 1'(k / 3) : 1'(k / 2);
            col_j   = hold_dim3_reg ? 2'(k % 3) : 2'(k % 2);
            col_ok  = hold_dim3_reg || (k < 2 * NODES_PER_EDGE);
            // Off-diagonal pairs xy, xz, yz sit at index i+j-1.
            off_idx = i_reg + col_j - 2'd1;
            if (hold_degen_reg || !col_ok)
                ent[k] = '0;
            else if (i_reg == col_j)
                ent[k] = (e_reg == col_f) ? plus_reg[i_reg] : minus_reg[i_reg];
            else
                ent[k] = off_reg[off_idx];
        end
        out_next.row_index  = row_reg;
        out_next.entry_0    = ent[0];
        out_next.entry_1    = ent[1];
        out_next.entry_2    = ent[2];
        out_next.entry_3    = ent[3];
        out_next.entry_4    = ent[4];
        out_next.entry_5    = ent[5];
        out_next.rhs_entry  = hold_degen_reg ? 32'd0 : rhs_reg[i_reg];
        out_next.degenerate = hold_degen_reg;
        out_next.last_row   = row_reg == size_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            row_reg       <= 3'd0;
            e_reg         <= 1'b0;
            i_reg         <= 2'd0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                row_reg    <= 3'd0;
                e_reg      <= 1'b0;
                i_reg      <= 2'd0;
            end
            else if (active_reg)
            begin
                if (row_reg == size_m1)
                    active_reg <= 1'b0;
                row_reg <= row_reg + 3'd1;
                if (i_reg == dim_m1)
                begin
                    i_reg <= 2'd0;
                    e_reg <= 1'b1;
                end
                else
                    i_reg <= i_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
            out_reg <= out_next;
    end

    assign row_valid = row_valid_reg;
    assign row_data  = out_reg;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for edge_gradient_local_system_top.
// Depends on egls_pkg; it predicts every matrix row of each edge item and checks them in order.
`timescale 1ns / 1ps

module testbench;
    import egls_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    egls_in_t  edge_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic      row_valid;
    egls_out_t row_data;

    edge_gradient_local_system_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .edge_data (edge_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_valid (row_valid),
        .row_data  (row_data)
    );

    typedef struct {
        egls_in_t item;
        bit       zero_len;
    } edge_case_t;

    egls_out_t   pending_rows[$];
    logic [1:0]  model_dim;
    logic [1:0]  model_vc;
    int          mismatches;
    int          quiet_cycles;
    bit          idle_enable;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [127:0] root_floor(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        logic [127:0] t;
        res  = '0;
        bitv = 128'd1 << 64;
        while (bitv != 0)
        begin
            t = res + bitv;
            if (v >= t)
            begin
                v   = v - t;
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded quotient, magnitude clamped to 2^32 and then signed.
    function automatic longint scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                            input int shift, input logic [127:0] q,
                                            input bit neg);
        logic [127:0] p;
        logic [127:0] m;
        longint v;
        p = ({64'd0, a} * {64'd0, b}) << shift;
        m = ((p << 1) + q) / (q << 1);
        v = (m > (128'd1 << 32)) ? 64'sh1_0000_0000 : longint'(m[63:0]);
        return neg ? -v : v;
    endfunction

    function automatic logic [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (x < -64'sd2147483648)
            return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic void predict_edge_rows(input egls_in_t it);
        longint       le[3];
        longint       dv;
        logic [63:0]  mag[3];
        logic [63:0]  dv_mag;
        logic [127:0] q;
        longint       eps;
        int           dim;
        int           size;
        int           vc;
        int           e;
        int           i;
        int           f;
        int           j;
        longint       v;
        logic [31:0]  cols[6];
        egls_out_t    row;
        dim  = (model_dim == DIM_TWO) ? 2 : 3;
        size = NODES_PER_EDGE * dim;
        vc   = (model_vc > 2) ? 2 : int'(model_vc);
        le[0] = longint'(it.second_x) - longint'(it.first_x);
        le[1] = longint'(it.second_y) - longint'(it.first_y);
        le[2] = longint'(it.second_z) - longint'(it.first_z);
        case (vc)
            0: dv = longint'(it.second_vel_x) - longint'(it.first_vel_x);
            1: dv = longint'(it.second_vel_y) - longint'(it.first_vel_y);
            default: dv = longint'(it.second_vel_z) - longint'(it.first_vel_z);
        endcase
        q = '0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = (le[k] < 0) ? -le[k] : le[k];
            q = q + {64'd0, mag[k]} * {64'd0, mag[k]};
        end
        dv_mag = (dv < 0) ? -dv : dv;
        eps = 0;
        if (q != 0)
            eps = longint'(((root_floor(q) * 128'd17592186) + (128'd1 << 29)) >> 30);
        for (int r = 0; r < size; r++)
        begin
            e = r / dim;
            i = r % dim;
            for (int k = 0; k < 6; k++)
                cols[k] = '0;
            row = '0;
            row.row_index  = r[2:0];
            row.degenerate = (q == 0);
            row.last_row   = (r == size - 1);
            if (q != 0)
            begin
                for (int k = 0; k < size; k++)
                begin
                    f = k / dim;
                    j = k % dim;
                    v = scaled_ratio(mag[i], mag[j], 30, q, (le[i] < 0) != (le[j] < 0));
                    if (i == j)
                        v = (e == f) ? v + eps : v - eps;
                    cols[k] = clamp32(v);
                end
                row.rhs_entry = clamp32(scaled_ratio(mag[i], dv_mag, 17, q,
                                                     (le[i] < 0) != (dv < 0)));
            end
            row.entry_0 = cols[0];
            row.entry_1 = cols[1];
            row.entry_2 = cols[2];
            row.entry_3 = cols[3];
            row.entry_4 = cols[4];
            row.entry_5 = cols[5];
            pending_rows.push_back(row);
        end
    endfunction

    // A zero-length edge needs no arithmetic: every row is zero and flagged.
    function automatic void expect_zero_rows();
        int size;
        egls_out_t row;
        size = NODES_PER_EDGE * ((model_dim == DIM_TWO) ? 2 : 3);
        for (int r = 0; r < size; r++)
        begin
            row = '0;
            row.row_index  = r[2:0];
            row.degenerate = 1'b1;
            row.last_row   = (r == size - 1);
            pending_rows.push_back(row);
        end
    endfunction

    task automatic gap_maybe();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_edge(input egls_in_t it, input bit zero_len);
        start     <= 1'b1;
        edge_data <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (zero_len)
            expect_zero_rows();
        else
            predict_edge_rows(it);
        gap_maybe();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DIMENSION)
            model_dim = val;
        else
            model_vc = val;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic egls_in_t random_edge();
        egls_in_t it;
        int mode;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            it.second_x = it.first_x;
            it.second_y = it.first_y;
            it.second_z = it.first_z;
        end
        else if (mode >= 5)
        begin
            // Short edges with small velocity differences keep results in range.
            it.second_x = it.first_x + $signed($urandom_range(0, 2 ** 21) - 2 ** 20);
            it.second_y = it.first_y + $signed($urandom_range(0, 2 ** 21) - 2 ** 20);
            it.second_z = it.first_z + $signed($urandom_range(0, 2 ** 21) - 2 ** 20);
            it.second_vel_x = it.first_vel_x + $signed($urandom_range(0, 2 ** 17) - 2 ** 16);
            it.second_vel_y = it.first_vel_y + $signed($urandom_range(0, 2 ** 17) - 2 ** 16);
            it.second_vel_z = it.first_vel_z + $signed($urandom_range(0, 2 ** 17) - 2 ** 16);
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        egls_out_t want;
        if (rst_n && row_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row %0d: %p", row_data.row_index, row_data);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (row_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch\n  expected %p\n  actual   %p", want, row_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || row_valid || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        edge_case_t  directed[$];
        edge_case_t  c;
        logic [1:0]  dims[8];
        logic [1:0]  vcs[8];
        egls_in_t    it;
        mismatches   = 0;
        idle_enable  = 1'b1;
        model_dim    = DIM_THREE;
        model_vc     = VC_X;
        rst_n        = 1'b0;
        start        = 1'b0;
        edge_data    = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length edges, at the origin and at both extremes.
        c.zero_len = 1'b1;
        c.item = '0;
        directed.push_back(c);
        c.item = {12{32'h8000_0000}};
        directed.push_back(c);
        c.item = {12{32'h7fff_ffff}};
        directed.push_back(c);
        c.zero_len = 1'b0;
        // Widest edge in each direction, largest velocity difference.
        c.item = {{3{32'h8000_0000}}, {3{32'h7fff_ffff}},
                  {3{32'h8000_0000}}, {3{32'h7fff_ffff}}};
        directed.push_back(c);
        c.item = {{3{32'h7fff_ffff}}, {3{32'h8000_0000}},
                  {3{32'h7fff_ffff}}, {3{32'h8000_0000}}};
        directed.push_back(c);
        // Unit edges along each axis and one negative, with modest velocities.
        for (int a = 0; a < 4; a++)
        begin
            c.item = '0;
            c.item.first_vel_x  = 32'h0001_0000;
            c.item.second_vel_y = 32'hfffe_0000;
            c.item.second_vel_z = 32'h0003_8000;
            case (a)
                0: c.item.second_x = 32'h0001_0000;
                1: c.item.second_y = 32'h0001_0000;
                2: c.item.second_z = 32'h0001_0000;
                default: c.item.first_x = 32'h0001_0000;
            endcase
            directed.push_back(c);
        end
        // Tiny edge against a huge velocity difference: the rhs saturates.
        c.item = '0;
        c.item.second_x     = 32'sd1;
        c.item.second_vel_x = 32'h7fff_ffff;
        c.item.first_vel_y  = 32'h8000_0000;
        c.item.first_vel_z  = 32'h7fff_ffff;
        directed.push_back(c);
        c.item.second_x = -32'sd1;
        directed.push_back(c);
        // Mainly z differs, with a one-LSB x step: a two-dimensional system still counts z in the length.
        c.item = '0;
        c.item.second_z    = 32'h0010_0000;
        c.item.second_x    = 32'h0000_0001;
        c.item.first_vel_x = 32'hffff_0000;
        directed.push_back(c);
        // Diagonal edge with all component magnitudes equal.
        c.item = '0;
        c.item.second_x = 32'h0002_0000;
        c.item.second_y = 32'hfffe_0000;
        c.item.second_z = 32'h0002_0000;
        c.item.second_vel_x = 32'h0000_8000;
        directed.push_back(c);

        // Settings; codes 0 and 1 for dimension fall back to three, code 3 picks z.
        dims = '{DIM_THREE, DIM_TWO, 2'd0, DIM_TWO, 2'd1, DIM_THREE, DIM_TWO, DIM_THREE};
        vcs  = '{VC_X, VC_Y, 2'd2, 2'd3, VC_Y, 2'd3, 2'd2, VC_X};

        foreach (directed[n])
            send_edge(directed[n].item, directed[n].zero_len);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_DIMENSION, dims[ph]);
            write_reg(CFG_VEL_COMPONENT, vcs[ph]);
            if (ph == 7)
                idle_enable = 1'b0;
            foreach (directed[n])
                if (ph == 1 || ph == 3)
                    send_edge(directed[n].item, directed[n].zero_len);
            for (int n = 0; n < 50; n++)
            begin
                it = random_edge();
                send_edge(it, 1'b0);
            end
            drain();
        end

        if (mismatches == 0 && pending_rows.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
design/egls_pkg.sv
design/egls_div.sv
design/egls_sqrt.sv
design/edge_gradient_local_system_top.sv
verif/testbench.sv
